// ----- design/xts_aes_sector_crypt_macros.svh -----
// Assertion helpers used by the top-level engine file to check behaviour.
`ifndef XTS_AES_SECTOR_CRYPT_MACROS_SVH
`define XTS_AES_SECTOR_CRYPT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define XTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define XTS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/xts_pkg.sv -----
`timescale 1ns / 1ps
package xts_pkg;

    localparam int BLOCKS_PER_SECTOR = 32;
    localparam logic [7:0] GF_REDUCTION = 8'h87;

    // Configuration register indexes
    localparam logic [1:0] CFG_DATA_KEY_LO  = 2'd0;
    localparam logic [1:0] CFG_DATA_KEY_HI  = 2'd1;
    localparam logic [1:0] CFG_TWEAK_KEY_LO = 2'd2;
    localparam logic [1:0] CFG_TWEAK_KEY_HI = 2'd3;

    // Datapath operations
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD_ITEM = 4'd1;
    localparam logic [3:0] OP_TW_LOAD   = 4'd2;
    localparam logic [3:0] OP_ROUND_ENC = 4'd3;
    localparam logic [3:0] OP_TW_STORE  = 4'd4;
    localparam logic [3:0] OP_SKIP_STEP = 4'd5;
    localparam logic [3:0] OP_KEY_INIT  = 4'd6;
    localparam logic [3:0] OP_KEY_FWD   = 4'd7;
    localparam logic [3:0] OP_DLOAD_ENC = 4'd8;
    localparam logic [3:0] OP_DLOAD_DEC = 4'd9;
    localparam logic [3:0] OP_ROUND_DEC = 4'd10;
    localparam logic [3:0] OP_FINISH    = 4'd11;

    localparam logic [3:0] LAST_ROUND = 4'd10;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] rnd;
    } xts_cmd_t;

    typedef struct packed {
        logic       encrypt;
        logic       run_start;
        logic       regenerate;
        logic [4:0] skip;
        logic       out_free;
    } xts_stat_t;

    typedef logic [7:0] byte_table_t [256];

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        logic [15:0] d;
        d = {x, x} << n;
        return d[15:8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Walk the multiplicative group with generator 3 and its inverse.
    function automatic byte_table_t make_sbox();
        byte_table_t t;
        logic [7:0]  p;
        logic [7:0]  q;
        logic [7:0]  x;
        p = 8'h01;
        q = 8'h01;
        for (int i = 0; i < 255; i++) begin
            p = p ^ xt(p);
            q = q ^ {q[6:0], 1'b0};
            q = q ^ {q[5:0], 2'b0};
            q = q ^ {q[3:0], 4'b0};
            if (q[7]) q = q ^ 8'h09;
            x = q ^ rotl8(q, 1) ^ rotl8(q, 2) ^ rotl8(q, 3) ^ rotl8(q, 4);
            t[p] = x ^ 8'h63;
        end
        t[0] = 8'h63;
        return t;
    endfunction

    function automatic byte_table_t make_inv_sbox();
        byte_table_t s;
        byte_table_t t;
        s = make_sbox();
        for (int i = 0; i < 256; i++) begin
            t[s[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam byte_table_t SBOX     = make_sbox();
    localparam byte_table_t INV_SBOX = make_inv_sbox();

    function automatic logic [7:0] rcon(input logic [3:0] n);
        logic [7:0] r;
        case (n)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] key_core(input logic [31:0] w, input logic [7:0] rc);
        logic [31:0] r;
        r = {w[7:0], w[31:24], w[23:16], w[15:8]};
        for (int j = 0; j < 4; j++) r[8*j +: 8] = SBOX[r[8*j +: 8]];
        r[7:0] = r[7:0] ^ rc;
        return r;
    endfunction

    function automatic logic [127:0] key_expand(input logic [127:0] k, input logic [7:0] rc);
        logic [127:0] n;
        n[31:0]   = k[31:0] ^ key_core(k[127:96], rc);
        n[63:32]  = k[63:32] ^ n[31:0];
        n[95:64]  = k[95:64] ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        return n;
    endfunction

    function automatic logic [127:0] key_inverse(input logic [127:0] k, input logic [7:0] rc);
        logic [127:0] p;
        p[127:96] = k[127:96] ^ k[95:64];
        p[95:64]  = k[95:64] ^ k[63:32];
        p[63:32]  = k[63:32] ^ k[31:0];
        p[31:0]   = k[31:0] ^ key_core(p[127:96], rc);
        return p;
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [127:0] t;
        logic [127:0] m;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[8*(c*4+r) +: 8] = SBOX[s[8*(((c+r)%4)*4+r) +: 8]];
        for (int c = 0; c < 4; c++) begin
            a0 = t[8*(c*4)   +: 8];
            a1 = t[8*(c*4+1) +: 8];
            a2 = t[8*(c*4+2) +: 8];
            a3 = t[8*(c*4+3) +: 8];
            m[8*(c*4)   +: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            m[8*(c*4+1) +: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            m[8*(c*4+2) +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            m[8*(c*4+3) +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return (last ? t : m) ^ rk;
    endfunction

    function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic mix);
        logic [127:0] t;
        logic [127:0] m;
        logic [7:0]   a [4];
        logic [7:0]   x2 [4];
        logic [7:0]   x4 [4];
        logic [7:0]   x8 [4];
        logic [7:0]   m9 [4];
        logic [7:0]   m11 [4];
        logic [7:0]   m13 [4];
        logic [7:0]   m14 [4];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[8*(((c+r)%4)*4+r) +: 8] = INV_SBOX[s[8*(c*4+r) +: 8]];
        t = t ^ rk;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j]   = t[8*(c*4+j) +: 8];
                x2[j]  = xt(a[j]);
                x4[j]  = xt(x2[j]);
                x8[j]  = xt(x4[j]);
                m9[j]  = x8[j] ^ a[j];
                m11[j] = x8[j] ^ x2[j] ^ a[j];
                m13[j] = x8[j] ^ x4[j] ^ a[j];
                m14[j] = x8[j] ^ x4[j] ^ x2[j];
            end
            m[8*(c*4)   +: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
            m[8*(c*4+1) +: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
            m[8*(c*4+2) +: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
            m[8*(c*4+3) +: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
        end
        return mix ? m : t;
    endfunction

    // One doubling in GF(2^128), little-endian.
    function automatic logic [127:0] gf_double(input logic [127:0] t);
        return {t[126:0], 1'b0} ^ {120'b0, (t[127] ? GF_REDUCTION : 8'h00)};
    endfunction

    // One sector's worth of doublings: multiply by x^32.
    function automatic logic [127:0] gf_mul_sector(input logic [127:0] t);
        logic [31:0] h;
        logic [38:0] c;
        h = t[127:96];
        c = {h, 7'b0} ^ {5'b0, h, 2'b0} ^ {6'b0, h, 1'b0} ^ {7'b0, h};
        return {t[95:0], 32'b0} ^ {89'b0, c};
    endfunction

endpackage

// ----- design/xts_ctrl.sv -----
`timescale 1ns / 1ps
module xts_ctrl
    import xts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  xts_stat_t stat,
    output xts_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_TWK   = 4'd2;
    localparam logic [3:0] ST_TWST  = 4'd3;
    localparam logic [3:0] ST_SKIP  = 4'd4;
    localparam logic [3:0] ST_DLOAD = 4'd5;
    localparam logic [3:0] ST_DENC  = 4'd6;
    localparam logic [3:0] ST_KEYX  = 4'd7;
    localparam logic [3:0] ST_DDEC0 = 4'd8;
    localparam logic [3:0] ST_DDEC  = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [3:0] rnd_reg, rnd_next;
    logic [4:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.rnd    = rnd_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.op     = OP_LOAD_ITEM;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (stat.run_start && stat.regenerate) begin
                    cmd.op     = OP_TW_LOAD;
                    rnd_next   = 4'd1;
                    state_next = ST_TWK;
                end else begin
                    cnt_next   = stat.run_start ? stat.skip : 5'd0;
                    state_next = ST_SKIP;
                end
            end
            ST_TWK: begin
                cmd.op   = OP_ROUND_ENC;
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == LAST_ROUND) state_next = ST_TWST;
            end
            ST_TWST: begin
                cmd.op     = OP_TW_STORE;
                cnt_next   = stat.skip;
                state_next = ST_SKIP;
            end
            ST_SKIP: begin
                if (cnt_reg == 5'd0) begin
                    state_next = ST_DLOAD;
                end else begin
                    cmd.op   = OP_SKIP_STEP;
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_DLOAD: begin
                rnd_next = 4'd1;
                if (stat.encrypt) begin
                    cmd.op     = OP_DLOAD_ENC;
                    state_next = ST_DENC;
                end else begin
                    cmd.op     = OP_KEY_INIT;
                    state_next = ST_KEYX;
                end
            end
            ST_DENC: begin
                cmd.op   = OP_ROUND_ENC;
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == LAST_ROUND) state_next = ST_FIN;
            end
            ST_KEYX: begin
                cmd.op   = OP_KEY_FWD;
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == LAST_ROUND) state_next = ST_DDEC0;
            end
            ST_DDEC0: begin
                cmd.op     = OP_DLOAD_DEC;
                rnd_next   = LAST_ROUND - 4'd1;
                state_next = ST_DDEC;
            end
            ST_DDEC: begin
                cmd.op   = OP_ROUND_DEC;
                rnd_next = rnd_reg - 4'd1;
                if (rnd_reg == 4'd0) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= 4'd0;
            cnt_reg   <= 5'd0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- design/xts_dpath.sv -----
`timescale 1ns / 1ps
module xts_dpath
    import xts_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  xts_cmd_t      cmd,
    output xts_stat_t     stat,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_wdata,
    input  logic [167:0]  in_data,
    input  logic [2:0]    in_user,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [127:0]  out_data
);

    logic [63:0]  dkey_lo_reg, dkey_hi_reg, tkey_lo_reg, tkey_hi_reg;
    logic [127:0] blk_reg;
    logic [31:0]  unit_reg;
    logic [4:0]   skip_reg;
    logic         enc_reg, run_reg, regen_reg;
    logic [127:0] state_reg, rk_reg, twk_reg, out_reg;
    logic         out_valid_reg;

    logic [127:0] rk_fwd, rk_back, unit_vec;

    assign rk_fwd   = key_expand(rk_reg, rcon(cmd.rnd));
    assign rk_back  = key_inverse(rk_reg, rcon(cmd.rnd + 4'd1));
    // unit number big-endian in bytes 12..15
    assign unit_vec = {unit_reg[7:0], unit_reg[15:8], unit_reg[23:16], unit_reg[31:24], 96'b0};

    assign stat.encrypt    = enc_reg;
    assign stat.run_start  = run_reg;
    assign stat.regenerate = regen_reg;
    assign stat.skip       = skip_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dkey_lo_reg   <= '0;
            dkey_hi_reg   <= '0;
            tkey_lo_reg   <= '0;
            tkey_hi_reg   <= '0;
            twk_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DATA_KEY_LO:  dkey_lo_reg <= cfg_wdata;
                    CFG_DATA_KEY_HI:  dkey_hi_reg <= cfg_wdata;
                    CFG_TWEAK_KEY_LO: tkey_lo_reg <= cfg_wdata;
                    CFG_TWEAK_KEY_HI: tkey_hi_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.op == OP_FINISH) out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_TW_STORE:  twk_reg <= state_reg;
                OP_SKIP_STEP: twk_reg <= gf_mul_sector(twk_reg);
                OP_FINISH:    twk_reg <= gf_double(twk_reg);
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD_ITEM: begin
                blk_reg   <= in_data[127:0];
                unit_reg  <= in_data[159:128];
                skip_reg  <= in_data[164:160];
                enc_reg   <= in_user[0];
                run_reg   <= in_user[1];
                regen_reg <= in_user[2];
            end
            OP_TW_LOAD: begin
                state_reg <= unit_vec ^ {tkey_hi_reg, tkey_lo_reg};
                rk_reg    <= {tkey_hi_reg, tkey_lo_reg};
            end
            OP_ROUND_ENC: begin
                state_reg <= enc_round(state_reg, rk_fwd, cmd.rnd == LAST_ROUND);
                rk_reg    <= rk_fwd;
            end
            OP_KEY_INIT:  rk_reg <= {dkey_hi_reg, dkey_lo_reg};
            OP_KEY_FWD:   rk_reg <= rk_fwd;
            OP_DLOAD_ENC: begin
                state_reg <= blk_reg ^ twk_reg ^ {dkey_hi_reg, dkey_lo_reg};
                rk_reg    <= {dkey_hi_reg, dkey_lo_reg};
            end
            OP_DLOAD_DEC: state_reg <= blk_reg ^ twk_reg ^ rk_reg;
            OP_ROUND_DEC: begin
                state_reg <= dec_round(state_reg, rk_back, cmd.rnd != 4'd0);
                rk_reg    <= rk_back;
            end
            OP_FINISH:    out_reg <= state_reg ^ twk_reg;
            default: ;
        endcase
    end

endmodule

// ----- design/xts_aes_sector_crypt.sv -----
// AES-128-XTS engine, one 16-byte block per transfer.
// Input stream s_*: s_tdata = block_lo, block_hi, unit_number, skip_sectors
// (low bit up, zero padded to 168 bits); s_tuser = encrypt, run_start,
// regenerate. Output stream m_*: m_tdata = out_lo, out_hi.
// Keys are loaded through cfg_we/cfg_index/cfg_wdata while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
// Each block runs on one iterative AES round unit, one round per cycle. On
// decrypt the data key schedule is first run forward to the last round key
// and then undone round by round. A run start with regeneration first
// encrypts the tweak; the sector skip multiplies it by x^32 per sector.
// One block is in flight at a time; s_tready rises again once the result
// sits in the output register, so a new block is taken while that result
// waits. If the receiver stalls, the next result is held back in the round
// unit until the output register frees. Reset clears keys and the running
// tweak to zero and empties the output register.
`timescale 1ns / 1ps
`include "xts_aes_sector_crypt_macros.svh"
module xts_aes_sector_crypt
    import xts_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [167:0] s_tdata,   // block_lo, block_hi, unit_number, skip_sectors, pad
    input  logic [2:0]   s_tuser,   // encrypt, run_start, regenerate
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // out_lo, out_hi
);

    xts_cmd_t  cmd;
    xts_stat_t stat;

    // Sequencer: steps the round unit and the tweak through each block
    xts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Round unit, key schedule, tweak and output register
    xts_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // One block in flight: no second transfer straight after the first
    `XTS_ASSERT_NXT(a_single_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "busy")
    // Never overwrite a result that has not been taken
    `XTS_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.op == OP_FINISH, !m_tvalid || m_tready, "overwrite")
    // A finished block always shows up as a valid result
    `XTS_ASSERT_NXT(a_finish_valid, aclk, aresetn, cmd.op == OP_FINISH, m_tvalid, "not presented")

endmodule
